// ===== design/tgsf_pkg.sv =====
// Shared types and constants for the text grid shape filler.
// Used by the front end, queue, back end and top level; depends on nothing.
`default_nettype none

package tgsf_pkg;

  // Frame geometry
  localparam int ROWS  = 25;
  localparam int COLS  = 80;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

  // Signed offset from the anchor, and unsigned squared distance
  localparam int DW   = 11;
  localparam int SQ_W = 18;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int QC_W   = $clog2(QDEPTH + 1);

  // Command codes as they arrive on the input channel
  typedef enum logic [2:0] {
    KIND_CLEAR  = 3'd0,
    KIND_DISC   = 3'd1,
    KIND_RECT   = 3'd2,
    KIND_TRI    = 3'd3,
    KIND_TREE   = 3'd4,
    KIND_MIRROR = 3'd5,
    KIND_READ   = 3'd6
  } kind_t;

  // Classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_DISC,
    OP_RECT,
    OP_TRI,
    OP_TREE,
    OP_MIRROR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [7:0]  col;
    logic signed [7:0]  row;
    logic [7:0]         size_a;
    logic [7:0]         size_b;
    logic [15:0]        a_sq;
    logic [15:0]        col_sq;
    logic [15:0]        row_sq;
    logic [8:0]         trunk_end;
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_CELL,
    ST_ROW_WR,
    ST_MIR_RD,
    ST_MIR_WA,
    ST_MIR_WB,
    ST_PEEK,
    ST_PICK,
    ST_RESP
  } bk_state_t;

endpackage

`default_nettype wire

// ===== design/tgsf_if.sv =====
// Valid/ready channel interfaces for commands and results.
// Depends on nothing.
`default_nettype none

interface tgsf_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic signed [7:0] col;
  logic signed [7:0] row;
  logic [7:0]        size_a;
  logic [7:0]        size_b;

  modport source (output valid, kind, col, row, size_a, size_b, input ready);
  modport sink   (input valid, kind, col, row, size_a, size_b, output ready);
endinterface

interface tgsf_out_if;
  logic valid;
  logic ready;
  logic cell_set;
  logic done_res;

  modport source (output valid, cell_set, done_res, input ready);
  modport sink   (input valid, cell_set, done_res, output ready);
endinterface

`default_nettype wire

// ===== design/tgsf_front.sv =====
// Front end: accepts command items, classifies them and precomputes squares.
// Depends on tgsf_pkg and tgsf_in_if.
`default_nettype none

module tgsf_front (
  input  logic            clk,
  input  logic            rst_n,
  tgsf_in_if.sink         in_ch,
  output logic            q_valid,
  input  logic            q_ready,
  output tgsf_pkg::cmd_t  q_cmd
);

  logic           f_vld_r;
  logic           f_vld_nxt;
  tgsf_pkg::cmd_t f_cmd_r;
  tgsf_pkg::cmd_t dec;
  logic           accept;
  logic [5:0]     quarter;
  logic [5:0]     trunk_len;
  logic signed [15:0] col_ext;
  logic signed [15:0] row_ext;
  logic           rd_in_frame;

  assign in_ch.ready = !f_vld_r || q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_valid     = f_vld_r;
  assign q_cmd       = f_cmd_r;

  // Classify the item and compute the squares the sweep starts from
  always_comb begin
    quarter   = in_ch.size_a[7:2];
    trunk_len = (quarter == 6'd0) ? 6'd1 : quarter;
    col_ext   = {{8{in_ch.col[7]}}, in_ch.col};
    row_ext   = {{8{in_ch.row[7]}}, in_ch.row};
    rd_in_frame = !in_ch.row[7] && ({1'b0, in_ch.row} < 9'(tgsf_pkg::ROWS)) &&
                  !in_ch.col[7] && ({1'b0, in_ch.col} < 9'(tgsf_pkg::COLS));

    dec           = '0;
    dec.col       = in_ch.col;
    dec.row       = in_ch.row;
    dec.size_a    = in_ch.size_a;
    dec.size_b    = in_ch.size_b;
    dec.a_sq      = {8'd0, in_ch.size_a} * {8'd0, in_ch.size_a};
    dec.col_sq    = 16'(col_ext * col_ext);
    dec.row_sq    = 16'(row_ext * row_ext);
    dec.trunk_end = {1'b0, in_ch.size_a} + {3'd0, trunk_len};

    case (in_ch.kind)
      tgsf_pkg::KIND_CLEAR:  dec.op = tgsf_pkg::OP_CLEAR;
      tgsf_pkg::KIND_DISC:   dec.op = tgsf_pkg::OP_DISC;
      tgsf_pkg::KIND_RECT:   dec.op = tgsf_pkg::OP_RECT;
      tgsf_pkg::KIND_TRI:    dec.op = tgsf_pkg::OP_TRI;
      tgsf_pkg::KIND_TREE:   dec.op = tgsf_pkg::OP_TREE;
      tgsf_pkg::KIND_MIRROR: dec.op = tgsf_pkg::OP_MIRROR;
      tgsf_pkg::KIND_READ:   dec.op = rd_in_frame ? tgsf_pkg::OP_READ : tgsf_pkg::OP_NOP;
      default:               dec.op = tgsf_pkg::OP_NOP;
    endcase
  end

  // Hold the stage until the queue takes it
  always_comb begin
    f_vld_nxt = f_vld_r;
    if (accept) begin
      f_vld_nxt = 1'b1;
    end else if (q_ready) begin
      f_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd_r <= dec;
    end
  end

endmodule

`default_nettype wire

// ===== design/tgsf_queue.sv =====
// Small command queue that decouples the front end from the back end.
// Depends on tgsf_pkg.
`default_nettype none

module tgsf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tgsf_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tgsf_pkg::cmd_t pop_cmd
);

  tgsf_pkg::cmd_t                 slot_r [tgsf_pkg::QDEPTH];
  logic [tgsf_pkg::QP_W-1:0]      wr_ptr_r;
  logic [tgsf_pkg::QP_W-1:0]      wr_ptr_nxt;
  logic [tgsf_pkg::QP_W-1:0]      rd_ptr_r;
  logic [tgsf_pkg::QP_W-1:0]      rd_ptr_nxt;
  logic [tgsf_pkg::QC_W-1:0]      cnt_r;
  logic [tgsf_pkg::QC_W-1:0]      cnt_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = (cnt_r != tgsf_pkg::QC_W'(tgsf_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== design/tgsf_back.sv =====
// Back end: frame memory, per-cell sweep sequencer and result register.
// Depends on tgsf_pkg.
`default_nettype none

module tgsf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  tgsf_pkg::cmd_t pop_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_cell_set
);

  localparam int ROWS  = tgsf_pkg::ROWS;
  localparam int COLS  = tgsf_pkg::COLS;
  localparam int ROW_W = tgsf_pkg::ROW_W;
  localparam int COL_W = tgsf_pkg::COL_W;
  localparam int DW    = tgsf_pkg::DW;
  localparam int SQ_W  = tgsf_pkg::SQ_W;
  localparam int HALF  = ROWS / 2;

  // Frame memory: one row per word, valid bit per row
  logic [COLS-1:0]  mem [ROWS];
  logic [ROWS-1:0]  row_vld_r;
  logic [COLS-1:0]  rd_data_a_r;
  logic [COLS-1:0]  rd_data_b_r;
  logic             rd_vld_a_r;
  logic             rd_vld_b_r;
  logic [ROW_W-1:0] rd_addr_a;
  logic [ROW_W-1:0] rd_addr_b;
  logic [ROW_W-1:0] wr_addr;
  logic [COLS-1:0]  wr_data;
  logic             mem_we;
  logic             clr_all;

  tgsf_pkg::bk_state_t state_r;
  tgsf_pkg::bk_state_t state_nxt;
  tgsf_pkg::cmd_t      cmd_r;
  tgsf_pkg::cmd_t      cmd_nxt;

  logic [ROW_W-1:0]     r_r, r_nxt;
  logic [COL_W-1:0]     c_r, c_nxt;
  logic signed [DW-1:0] dr_r, dr_nxt;
  logic signed [DW-1:0] dc_r, dc_nxt;
  logic [SQ_W-1:0]      dr_sq_r, dr_sq_nxt;
  logic [SQ_W-1:0]      dc_sq_r, dc_sq_nxt;
  logic [COLS-1:0]      row_buf_r, row_buf_nxt;
  logic                 res_cell_r, res_cell_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 out_cell_r, out_cell_nxt;

  logic [ROW_W-1:0]     mir_row;
  logic [ROW_W-1:0]     rd_row;
  logic [COL_W-1:0]     rd_col;
  logic signed [DW-1:0] a_s;
  logic signed [DW-1:0] b_s;
  logic signed [DW-1:0] te_s;
  logic [SQ_W-1:0]      dr_ext;
  logic [SQ_W-1:0]      dc_ext;
  logic [SQ_W-1:0]      dr_step;
  logic [SQ_W-1:0]      dc_step;
  logic signed [DW-1:0] row_neg;
  logic signed [DW-1:0] col_neg;
  logic                 hit;
  logic                 out_free;

  assign mir_row  = ROW_W'(ROWS - 1) - r_r;
  assign rd_row   = cmd_r.row[ROW_W-1:0];
  assign rd_col   = cmd_r.col[COL_W-1:0];
  assign a_s      = $signed({{(DW-8){1'b0}}, cmd_r.size_a});
  assign b_s      = $signed({{(DW-8){1'b0}}, cmd_r.size_b});
  assign te_s     = $signed({{(DW-9){1'b0}}, cmd_r.trunk_end});
  assign out_free = !out_vld_r || out_ready;

  // Squares step by (2d + 1) as the offset moves by one
  assign dr_ext  = {{(SQ_W-DW){dr_r[DW-1]}}, dr_r};
  assign dc_ext  = {{(SQ_W-DW){dc_r[DW-1]}}, dc_r};
  assign dr_step = {dr_ext[SQ_W-2:0], 1'b1};
  assign dc_step = {dc_ext[SQ_W-2:0], 1'b1};
  assign row_neg = -$signed({{(DW-8){pop_cmd.row[7]}}, pop_cmd.row});
  assign col_neg = -$signed({{(DW-8){cmd_r.col[7]}}, cmd_r.col});

  // Shape test for the current cell
  always_comb begin
    hit = 1'b0;
    case (cmd_r.op)
      tgsf_pkg::OP_DISC: begin
        hit = (dr_sq_r + dc_sq_r) <= {{(SQ_W-16){1'b0}}, cmd_r.a_sq};
      end
      tgsf_pkg::OP_RECT: begin
        hit = !dr_r[DW-1] && (dr_r < b_s) && !dc_r[DW-1] && (dc_r < a_s);
      end
      tgsf_pkg::OP_TRI: begin
        hit = !dr_r[DW-1] && (dc_r >= dr_r) && (dc_r < a_s - dr_r);
      end
      tgsf_pkg::OP_TREE: begin
        if (!dr_r[DW-1] && (dr_r < a_s)) begin
          hit = (dc_r >= -dr_r) && (dc_r <= dr_r);
        end else begin
          hit = (dc_r == '0) && (dr_r >= a_s) && (dr_r < te_s);
        end
      end
      default: hit = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgsf_pkg::ST_IDLE: begin
        if (pop_valid) begin
          if (pop_cmd.op inside {tgsf_pkg::OP_DISC, tgsf_pkg::OP_RECT,
                                 tgsf_pkg::OP_TRI, tgsf_pkg::OP_TREE}) begin
            state_nxt = tgsf_pkg::ST_ROW_RD;
          end else if (pop_cmd.op == tgsf_pkg::OP_CLEAR) begin
            state_nxt = tgsf_pkg::ST_CLEAR;
          end else if (pop_cmd.op == tgsf_pkg::OP_MIRROR && HALF > 0) begin
            state_nxt = tgsf_pkg::ST_MIR_RD;
          end else if (pop_cmd.op == tgsf_pkg::OP_READ) begin
            state_nxt = tgsf_pkg::ST_PEEK;
          end else begin
            state_nxt = tgsf_pkg::ST_RESP;
          end
        end
      end
      tgsf_pkg::ST_CLEAR:  state_nxt = tgsf_pkg::ST_RESP;
      tgsf_pkg::ST_ROW_RD: state_nxt = tgsf_pkg::ST_ROW_LD;
      tgsf_pkg::ST_ROW_LD: state_nxt = tgsf_pkg::ST_CELL;
      tgsf_pkg::ST_CELL: begin
        if (c_r == COL_W'(COLS - 1)) begin
          state_nxt = tgsf_pkg::ST_ROW_WR;
        end
      end
      tgsf_pkg::ST_ROW_WR: begin
        state_nxt = (r_r == ROW_W'(ROWS - 1)) ? tgsf_pkg::ST_RESP : tgsf_pkg::ST_ROW_RD;
      end
      tgsf_pkg::ST_MIR_RD: state_nxt = tgsf_pkg::ST_MIR_WA;
      tgsf_pkg::ST_MIR_WA: state_nxt = tgsf_pkg::ST_MIR_WB;
      tgsf_pkg::ST_MIR_WB: begin
        state_nxt = (r_r == ROW_W'(HALF - 1)) ? tgsf_pkg::ST_RESP : tgsf_pkg::ST_MIR_RD;
      end
      tgsf_pkg::ST_PEEK: state_nxt = tgsf_pkg::ST_PICK;
      tgsf_pkg::ST_PICK: state_nxt = tgsf_pkg::ST_RESP;
      tgsf_pkg::ST_RESP: begin
        if (out_free) begin
          state_nxt = tgsf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tgsf_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls and register updates per state
  always_comb begin
    pop_ready    = 1'b0;
    mem_we       = 1'b0;
    clr_all      = 1'b0;
    wr_addr      = r_r;
    wr_data      = row_buf_r;
    rd_addr_a    = r_r;
    rd_addr_b    = mir_row;
    cmd_nxt      = cmd_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    dr_nxt       = dr_r;
    dc_nxt       = dc_r;
    dr_sq_nxt    = dr_sq_r;
    dc_sq_nxt    = dc_sq_r;
    row_buf_nxt  = row_buf_r;
    res_cell_nxt = res_cell_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_cell_nxt = out_cell_r;

    case (state_r)
      tgsf_pkg::ST_IDLE: begin
        pop_ready    = 1'b1;
        cmd_nxt      = pop_cmd;
        r_nxt        = '0;
        dr_nxt       = row_neg;
        dr_sq_nxt    = {{(SQ_W-16){1'b0}}, pop_cmd.row_sq};
        res_cell_nxt = 1'b0;
      end
      tgsf_pkg::ST_CLEAR: begin
        clr_all = 1'b1;
      end
      tgsf_pkg::ST_ROW_LD: begin
        row_buf_nxt = rd_data_a_r & {COLS{rd_vld_a_r}};
        c_nxt       = '0;
        dc_nxt      = col_neg;
        dc_sq_nxt   = {{(SQ_W-16){1'b0}}, cmd_r.col_sq};
      end
      tgsf_pkg::ST_CELL: begin
        row_buf_nxt[c_r] = row_buf_r[c_r] | hit;
        c_nxt            = c_r + 1'b1;
        dc_nxt           = dc_r + 1'b1;
        dc_sq_nxt        = dc_sq_r + dc_step;
      end
      tgsf_pkg::ST_ROW_WR: begin
        mem_we    = 1'b1;
        r_nxt     = r_r + 1'b1;
        dr_nxt    = dr_r + 1'b1;
        dr_sq_nxt = dr_sq_r + dr_step;
      end
      tgsf_pkg::ST_MIR_WA: begin
        mem_we  = 1'b1;
        wr_data = rd_data_b_r & {COLS{rd_vld_b_r}};
      end
      tgsf_pkg::ST_MIR_WB: begin
        mem_we  = 1'b1;
        wr_addr = mir_row;
        wr_data = rd_data_a_r & {COLS{rd_vld_a_r}};
        r_nxt   = r_r + 1'b1;
      end
      tgsf_pkg::ST_PEEK: begin
        rd_addr_a = rd_row;
      end
      tgsf_pkg::ST_PICK: begin
        res_cell_nxt = rd_data_a_r[rd_col] & rd_vld_a_r;
      end
      tgsf_pkg::ST_RESP: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_cell_nxt = res_cell_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tgsf_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
      row_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      if (clr_all) begin
        row_vld_r <= '0;
      end else if (mem_we) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Sweep datapath
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    dr_r       <= dr_nxt;
    dc_r       <= dc_nxt;
    dr_sq_r    <= dr_sq_nxt;
    dc_sq_r    <= dc_sq_nxt;
    row_buf_r  <= row_buf_nxt;
    res_cell_r <= res_cell_nxt;
    out_cell_r <= out_cell_nxt;
  end

  // Frame memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
    rd_vld_a_r  <= row_vld_r[rd_addr_a];
    rd_vld_b_r  <= row_vld_r[rd_addr_b];
  end

  assign out_valid    = out_vld_r;
  assign out_cell_set = out_cell_r;

endmodule

`default_nettype wire

// ===== design/text_grid_shape_filler_unit.sv =====
// Top level of the text grid shape filler: front end, queue, back end.
// Depends on tgsf_pkg, tgsf_if, tgsf_front, tgsf_queue and tgsf_back.
//
// Usage:
//   in_ch carries one command per item (kind, col, row, size_a, size_b);
//   out_ch returns exactly one result per command, in order, with
//   done_res = 1 and cell_set holding the cell value for a read.
//   The frame is 25 rows by 80 columns of one bit, kept as one memory word
//   per row plus a valid bit per row, so a clear resets only the valid bits.
// Sequencing in the back end, from the command the queue hands over:
//   draw commands sweep each row as read, load, each column's cell in turn,
//   write; mirror swaps each row of the top half with its mirror row,
//   reading both, then writing each; clear drops every valid bit; read fetches
//   the row and picks the cell; an off-frame read or unknown kind just answers.
//   The back end's single row-write port sets the pace: one command at a time.
// Buffering: a front register and a two-entry queue keep accepting commands
//   while the back end works; a finished result waits in the output register
//   and the back end holds its next result until the receiver takes it.
// Reset: rst_n (synchronous, active low) empties every stage and blanks the
//   frame at once; in_ch.ready is high in the first cycle after reset.
`default_nettype none

module text_grid_shape_filler_unit (
  input  logic         clk,
  input  logic         rst_n,
  tgsf_in_if.sink      in_ch,
  tgsf_out_if.source   out_ch
);

  logic           q_push_valid;
  logic           q_push_ready;
  tgsf_pkg::cmd_t q_push_cmd;
  logic           q_pop_valid;
  logic           q_pop_ready;
  tgsf_pkg::cmd_t q_pop_cmd;
  logic           bk_out_valid;
  logic           bk_out_cell;

  tgsf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_push_valid),
    .q_ready (q_push_ready),
    .q_cmd   (q_push_cmd)
  );

  tgsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (q_push_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_cmd    (q_pop_cmd)
  );

  tgsf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (q_pop_valid),
    .pop_ready    (q_pop_ready),
    .pop_cmd      (q_pop_cmd),
    .out_valid    (bk_out_valid),
    .out_ready    (out_ch.ready),
    .out_cell_set (bk_out_cell)
  );

  // Every command completes, so done is constant on a valid result
  assign out_ch.valid    = bk_out_valid;
  assign out_ch.cell_set = bk_out_cell;
  assign out_ch.done_res = 1'b1;

endmodule

`default_nettype wire

// ===== design/tgsf_checker.sv =====
// Port-level checks for text_grid_shape_filler_unit, attached by bind.
// Depends on the top level's channel interfaces only.
`default_nettype none

module tgsf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_cell_set
);

  logic [3:0] pend_r;
  logic [3:0] pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track items accepted but not yet answered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_set))
    else $error("result changed while stalled");

  // No result without an outstanding item
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without a pending item");

  // Front register, queue, back end and output register bound the items in flight
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd5)
    else $error("more items in flight than storage");

  // With every slot full the block must refuse input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 4'd5 |-> !in_ready)
    else $error("input taken while every slot is full");

endmodule

bind text_grid_shape_filler_unit tgsf_checker u_tgsf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_cell_set (out_ch.cell_set)
);

`default_nettype wire
